@@ rtl/round_robin_time_slice_scheduler_defines.svh @@
// assertion macros for the round-robin time-slice scheduler
// depends on nothing; expects clk and arst_n in the scope of each use
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define RRTS_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// next-cycle implication, checked out of reset
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`else

`define RRTS_ASSERT(lbl, ante, cons)
`define RRTS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/rrts_pkg.sv @@
// shared types and constants of the round-robin time-slice scheduler
// depends on nothing
package rrts_pkg;

	localparam int MAX_JOBS_DEFAULT = 64;
	localparam int ID_W             = 6;
	localparam int BURST_W          = 16;
	localparam int QUANTUM_W        = 8;
	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;

	// request codes
	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	// one queue slot as kept in memory
	typedef struct packed {
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// result of one tick
	typedef struct packed {
		logic            ran;
		logic [ID_W-1:0] running_job;
		logic            job_finished;
		logic            job_preempted;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} state_t;

endpackage

@@ rtl/rrts_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/rrts_core.sv @@
// queue control of the scheduler: head, tail, count, slice counter, slot ram access
// depends on rrts_pkg and the assertion macro header
`include "round_robin_time_slice_scheduler_defines.svh"

module rrts_core import rrts_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [ID_W-1:0]             job_id,
	input  logic [BURST_W-1:0]          burst_length,
	input  logic [QUANTUM_W-1:0]        time_quantum,
	output logic                        res_valid,
	input  logic                        res_ready,
	output result_t                     res,
	output logic                        ram_we,
	output logic [$clog2(MAX_JOBS)-1:0] ram_waddr,
	output slot_t                       ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(MAX_JOBS)-1:0] ram_raddr,
	input  slot_t                       ram_rdata
);

	localparam int AW    = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam logic [AW-1:0]    LAST_SLOT = AW'(MAX_JOBS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_JOBS);

	state_t                 state_q;
	logic [AW-1:0]          head_q;
	logic [AW-1:0]          tail_q;
	logic [CNT_W-1:0]       count_q;
	logic [QUANTUM_W-1:0]   slice_q;

	logic                   accept;
	logic                   do_arrival;
	logic                   do_tick;
	logic                   finish_tick;
	logic                   busy;
	logic [BURST_W-1:0]     left;
	logic [QUANTUM_W-1:0]   slice_dec;
	logic [QUANTUM_W-1:0]   full_slice;
	logic                   is_done;
	logic                   is_preempt;
	logic [AW-1:0]          head_nxt;
	logic [AW-1:0]          tail_nxt;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
		return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
	endfunction

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign do_arrival = accept && (req_type == REQ_ARRIVAL) && (burst_length != '0)
		&& (count_q < FULL_CNT);
	assign do_tick    = accept && (req_type == REQ_TICK);

	assign res_valid   = (state_q == ST_TICK);
	assign finish_tick = res_valid && res_ready;
	assign busy        = (count_q != '0);

	assign left       = (ram_rdata.burst != '0) ? ram_rdata.burst - 1'b1 : '0;
	assign slice_dec  = (slice_q != '0) ? slice_q - 1'b1 : '0;
	assign full_slice = (time_quantum == '0) ? QUANTUM_W'(1) : time_quantum;
	assign is_done    = busy && (left == '0);
	assign is_preempt = busy && !is_done && (slice_dec == '0);
	assign head_nxt   = next_slot(head_q);
	assign tail_nxt   = next_slot(tail_q);

	always_comb begin
		res.ran           = busy;
		res.running_job   = busy ? ram_rdata.job_id : '0;
		res.job_finished  = is_done;
		res.job_preempted = is_preempt;
	end

	// head read on tick accept; write on arrival or tick write-back
	assign ram_re    = do_tick;
	assign ram_raddr = head_q;

	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = tail_q;
		ram_wdata.job_id = job_id;
		ram_wdata.burst  = burst_length;
		if (do_arrival) begin
			ram_we = 1'b1;
		end else if (finish_tick && busy && !is_done) begin
			ram_we           = 1'b1;
			ram_waddr        = is_preempt ? tail_q : head_q;
			ram_wdata.job_id = ram_rdata.job_id;
			ram_wdata.burst  = left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			slice_q <= QUANTUM_RESET;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_arrival) begin
						tail_q  <= tail_nxt;
						count_q <= count_q + 1'b1;
					end
					if (do_tick) begin
						state_q <= ST_TICK;
					end
				end
				ST_TICK: begin
					if (finish_tick) begin
						state_q <= ST_IDLE;
						if (is_done) begin
							head_q  <= head_nxt;
							count_q <= count_q - 1'b1;
							slice_q <= full_slice;
						end else if (is_preempt) begin
							head_q  <= head_nxt;
							tail_q  <= tail_nxt;
							slice_q <= full_slice;
						end else if (busy) begin
							slice_q <= slice_dec;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RRTS_ASSERT(a_count_bound, 1'b1, count_q <= FULL_CNT)
	`RRTS_ASSERT(a_ptr_meet, (count_q == '0) || (count_q == FULL_CNT), head_q == tail_q)
	`RRTS_ASSERT(a_no_rw_overlap, ram_re, !ram_we)
	`RRTS_ASSERT_NEXT(a_tick_done, finish_tick, state_q == ST_IDLE)

endmodule

@@ rtl/round_robin_time_slice_scheduler.sv @@
// Round-robin time-slice scheduler. An arrival item (req_type 0) appends a job id and its
// burst length to a circular ready queue held in one slot ram; a zero burst or a full
// queue drops it. A tick item (req_type 1) runs the head job for one unit and returns one
// result: ran, running_job, and whether the job finished (retired) or was preempted (its
// slice ran out and it moved to the tail). An empty queue gives an idle result, all zero.
// An arrival gives no result. A tick reads the head slot (registered), then updates and
// writes it back once the output register takes the result. Results sit in an output
// register, so new items are taken while a result waits downstream. time_quantum (reset
// 4, zero acts as one) must be written through the cfg port while idle (the block does
// not enforce this) and takes effect at the next slice reload. No clearing pass is needed
// after reset. Depends on rrts_pkg, rrts_ram, rrts_core and the assertion macro header.
`include "round_robin_time_slice_scheduler_defines.svh"

module round_robin_time_slice_scheduler import rrts_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item input
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [ID_W-1:0]      job_id,
	input  logic [BURST_W-1:0]   burst_length,
	// quantum register write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [QUANTUM_W-1:0] cfg_data,
	// tick results
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 ran,
	output logic [ID_W-1:0]      running_job,
	output logic                 job_finished,
	output logic                 job_preempted
);

	localparam int AW = $clog2(MAX_JOBS);

	logic [QUANTUM_W-1:0] quantum_q;
	logic                 out_valid_q;
	result_t              out_q;

	// core to output register
	logic                 res_valid;
	logic                 res_ready;
	result_t              res;

	// slot ram connections
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SLOT_W-1:0]    ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [SLOT_W-1:0]    ram_rdata;

	// register write always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	// output register frees up when empty or when its item is taken this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign ran           = out_q.ran;
	assign running_job   = out_q.running_job;
	assign job_finished  = out_q.job_finished;
	assign job_preempted = out_q.job_preempted;

	// job id and remaining burst, one slot per queue position
	rrts_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_JOBS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rrts_core #(
		.MAX_JOBS(MAX_JOBS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.job_id      (job_id),
		.burst_length(burst_length),
		.time_quantum(quantum_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// a job either retires or rotates, never both, and idle results carry nothing
	`RRTS_ASSERT(a_one_outcome, out_valid_q, !(out_q.job_finished && out_q.job_preempted))
	`RRTS_ASSERT(a_idle_clean, out_valid_q && !out_q.ran,
		!out_q.job_finished && !out_q.job_preempted)

endmodule
